// File: sv/urtb_pkg.sv
// ----------------------------------------------------------------------------
// urtb_pkg
// Shared types and sizes for the UART receive and transmit ring buffers.
// ----------------------------------------------------------------------------
package urtb_pkg;

   localparam int RX_DEPTH = 64;
   localparam int TX_DEPTH = 64;
   localparam int RX_AW    = $clog2(RX_DEPTH);
   localparam int TX_AW    = $clog2(TX_DEPTH);

   typedef enum logic [1:0] {
      REQ_RX_BYTE    = 2'd0,
      REQ_HOST_READ  = 2'd1,
      REQ_HOST_WRITE = 2'd2,
      REQ_TX_READY   = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] data_byte;
      logic       frame_err_in;
      logic       overrun_in;
      logic       parity_err_in;
   } urtb_req_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic       read_valid;
      logic [7:0] send_byte;
      logic       send_valid;
      logic       rx_overflow;
      logic       frame_flag;
      logic       overrun_flag;
      logic       parity_flag;
      logic       tx_overflow;
      logic       tx_pending;
   } urtb_rsp_type;

endpackage

// File: sv/uart_rx_tx_ring_buffers.sv
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers
// Receive and transmit byte ring buffers between a UART and its host.
// ----------------------------------------------------------------------------
// Each accepted item is one event: a byte received from the line, a host
// read, a host write, or a transmitter-ready event. Every item yields exactly
// one result item. The block takes one item per clock cycle while the rsp_
// side keeps up. A result passes stage one, where the byte read from a buffer
// comes out of a synchronous memory with a registered read, and then passes
// an output register on the rsp_ side. Each buffer is a ring in its
// own memory, written at the head slot and read at the tail slot, and keeps
// one slot free, so it holds RX_DEPTH-1 or TX_DEPTH-1 bytes. Head and tail
// pointers are updated as an item is accepted, so the next item already sees
// the new occupancy. A pop that follows the push of the same entry in the
// next cycle reads the memory after that write has landed, so no forwarding
// is needed. A full receive buffer drops the byte and raises rx_overflow; a
// full transmit buffer drops the host byte and raises tx_overflow. Reads of
// an empty buffer return zero with the valid bit low. The memories need no
// clearing: only entries between tail and head are ever read. When rsp_ready
// is held low the two internal stages fill and req_ready drops.
// ----------------------------------------------------------------------------
module uart_rx_tx_ring_buffers (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  urtb_pkg::urtb_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output urtb_pkg::urtb_rsp_type rsp_data
);
   import urtb_pkg::*;

   // Buffer memories.
   logic [7:0] rx_store [RX_DEPTH];
   logic [7:0] tx_store [TX_DEPTH];

   // Pointers.
   logic [RX_AW-1:0] rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [TX_AW-1:0] tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic [RX_AW-1:0] rx_head_nxt, rx_tail_nxt;
   logic [TX_AW-1:0] tx_head_nxt, tx_tail_nxt;

   // Memory read data.
   logic [7:0] rx_rd_ff, tx_rd_ff;

   // Stage one: result without the popped bytes, waiting for read data.
   logic         p1_valid_ff, p1_valid_in;
   urtb_rsp_type p1_rsp_ff, p1_rsp_in;

   // Stage two: output register.
   logic         out_valid_ff, out_valid_in;
   urtb_rsp_type out_rsp_ff, out_rsp_in;

   logic accept, p1_move;
   logic rx_push, rx_pop, tx_push, tx_pop;
   logic rx_full, rx_empty, tx_full, tx_empty;
   req_kind_type kind;

   assign kind = req_kind_type'(req_data.req_type);

   // Stage two frees when its item is taken or it is empty.
   assign p1_move   = p1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !p1_valid_ff || p1_move;
   assign accept    = req_valid && req_ready;

   assign rx_head_nxt = (rx_head_ff == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head_ff + 1'b1;
   assign rx_tail_nxt = (rx_tail_ff == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_tail_ff + 1'b1;
   assign tx_head_nxt = (tx_head_ff == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head_ff + 1'b1;
   assign tx_tail_nxt = (tx_tail_ff == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_tail_ff + 1'b1;

   assign rx_full  = (rx_head_nxt == rx_tail_ff);
   assign rx_empty = (rx_head_ff == rx_tail_ff);
   assign tx_full  = (tx_head_nxt == tx_tail_ff);
   assign tx_empty = (tx_head_ff == tx_tail_ff);

   always_comb begin
      rx_push = 1'b0;
      rx_pop  = 1'b0;
      tx_push = 1'b0;
      tx_pop  = 1'b0;
      p1_rsp_in = '0;
      unique case (kind)
         REQ_RX_BYTE: begin
            rx_push                = !rx_full;
            p1_rsp_in.rx_overflow  = rx_full;
            p1_rsp_in.frame_flag   = req_data.frame_err_in;
            p1_rsp_in.overrun_flag = req_data.overrun_in;
            p1_rsp_in.parity_flag  = req_data.parity_err_in;
         end
         REQ_HOST_READ: begin
            rx_pop               = !rx_empty;
            p1_rsp_in.read_valid = !rx_empty;
         end
         REQ_HOST_WRITE: begin
            tx_push               = !tx_full;
            p1_rsp_in.tx_overflow = tx_full;
         end
         REQ_TX_READY: begin
            tx_pop               = !tx_empty;
            p1_rsp_in.send_valid = !tx_empty;
         end
         default: begin
         end
      endcase
      rx_head_in = (accept && rx_push) ? rx_head_nxt : rx_head_ff;
      rx_tail_in = (accept && rx_pop)  ? rx_tail_nxt : rx_tail_ff;
      tx_head_in = (accept && tx_push) ? tx_head_nxt : tx_head_ff;
      tx_tail_in = (accept && tx_pop)  ? tx_tail_nxt : tx_tail_ff;
      // Transmit occupancy after this item.
      p1_rsp_in.tx_pending = (tx_head_in != tx_tail_in);
   end

   always_comb begin
      p1_valid_in = accept ? 1'b1 : (p1_move ? 1'b0 : p1_valid_ff);
      if (p1_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
      out_rsp_in           = p1_rsp_ff;
      out_rsp_in.read_byte = p1_rsp_ff.read_valid ? rx_rd_ff : 8'd0;
      out_rsp_in.send_byte = p1_rsp_ff.send_valid ? tx_rd_ff : 8'd0;
   end

   // Memories: one write and one registered read each. The read address is
   // the tail before this item's update.
   always_ff @(posedge clock) begin
      if (accept && rx_push) begin
         rx_store[rx_head_ff] <= req_data.data_byte;
      end
      if (accept) begin
         rx_rd_ff <= rx_store[rx_tail_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (accept && tx_push) begin
         tx_store[tx_head_ff] <= req_data.data_byte;
      end
      if (accept) begin
         tx_rd_ff <= tx_store[tx_tail_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_head_ff   <= '0;
         rx_tail_ff   <= '0;
         tx_head_ff   <= '0;
         tx_tail_ff   <= '0;
         p1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rx_head_ff   <= rx_head_in;
         rx_tail_ff   <= rx_tail_in;
         tx_head_ff   <= tx_head_in;
         tx_tail_ff   <= tx_tail_in;
         p1_valid_ff  <= p1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p1_rsp_ff <= p1_rsp_in;
      end
      if (p1_move) begin
         out_rsp_ff <= out_rsp_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_rsp_ff;

endmodule

// File: test/tb_uart_rx_tx_ring_buffers.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uart_rx_tx_ring_buffers
// Self-checking bench for the UART receive and transmit ring buffers.
// ----------------------------------------------------------------------------
// A short list of hand-picked items covers the empty and edge cases first.
// Long random segments follow, most biased toward one request kind, so both
// rings are driven full and drained empty many times. A software copy of both
// rings predicts every result item, and each result is compared field by
// field against the oldest prediction. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module tb_uart_rx_tx_ring_buffers;
   import urtb_pkg::*;

   localparam int RANDOM_ITEMS = 1800;
   localparam int RESET_CYCLES = 12;
   // Slack to watch for any stray result after the last one arrives.
   localparam int DRAIN_CYCLES = 10;
   // Worst legal quiet stretch is the longest sender gap stacked on the longest
   // receiver stall and the pipeline latency; this is many times that.
   localparam int IDLE_LIMIT   = 300;

   // Shadow copy of both rings. Every accepted request item is applied here
   // in order, and the result it should produce is queued for comparison.
   class ring_buffer_predictor;
      logic [7:0]       rx_mem [RX_DEPTH];
      logic [7:0]       tx_mem [TX_DEPTH];
      logic [RX_AW-1:0] rx_head;
      logic [RX_AW-1:0] rx_tail;
      logic [TX_AW-1:0] tx_head;
      logic [TX_AW-1:0] tx_tail;
      urtb_rsp_type     expected_rsps [$];
      int               mismatch_cnt;

      function new();
         rx_head      = '0;
         rx_tail      = '0;
         tx_head      = '0;
         tx_tail      = '0;
         mismatch_cnt = 0;
      endfunction

      function logic [RX_AW-1:0] rx_next(logic [RX_AW-1:0] p);
         return (int'(p) + 1 >= RX_DEPTH) ? '0 : p + 1'b1;
      endfunction

      function logic [TX_AW-1:0] tx_next(logic [TX_AW-1:0] p);
         return (int'(p) + 1 >= TX_DEPTH) ? '0 : p + 1'b1;
      endfunction

      function string describe(urtb_rsp_type r);
         return $sformatf("rd=%02h/%0b snd=%02h/%0b rxo=%0b fe=%0b ov=%0b pe=%0b txo=%0b pend=%0b",
            r.read_byte, r.read_valid, r.send_byte, r.send_valid, r.rx_overflow,
            r.frame_flag, r.overrun_flag, r.parity_flag, r.tx_overflow, r.tx_pending);
      endfunction

      function void note_request(urtb_req_type req);
         urtb_rsp_type rsp;
         rsp = '0;
         case (req_kind_type'(req.req_type))
            REQ_RX_BYTE: begin
               if (rx_next(rx_head) == rx_tail) begin
                  rsp.rx_overflow = 1'b1;
               end else begin
                  rx_mem[rx_head] = req.data_byte;
                  rx_head = rx_next(rx_head);
               end
               // Status bits are echoed even when the byte is dropped.
               rsp.frame_flag   = req.frame_err_in;
               rsp.overrun_flag = req.overrun_in;
               rsp.parity_flag  = req.parity_err_in;
            end
            REQ_HOST_READ: begin
               if (rx_head != rx_tail) begin
                  rsp.read_byte  = rx_mem[rx_tail];
                  rsp.read_valid = 1'b1;
                  rx_tail = rx_next(rx_tail);
               end
            end
            REQ_HOST_WRITE: begin
               if (tx_next(tx_head) == tx_tail) begin
                  rsp.tx_overflow = 1'b1;
               end else begin
                  tx_mem[tx_head] = req.data_byte;
                  tx_head = tx_next(tx_head);
               end
            end
            default: begin
               if (tx_head != tx_tail) begin
                  rsp.send_byte  = tx_mem[tx_tail];
                  rsp.send_valid = 1'b1;
                  tx_tail = tx_next(tx_tail);
               end
            end
         endcase
         rsp.tx_pending = (tx_head != tx_tail);
         expected_rsps.push_back(rsp);
      endfunction

      function void check_response(urtb_rsp_type got);
         urtb_rsp_type want;
         string        bad;
         if (expected_rsps.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
               $display("unexpected result item: %s", describe(got));
            end
            return;
         end
         want = expected_rsps.pop_front();
         bad  = "";
         if (got.read_byte    !== want.read_byte)    bad = {bad, " read_byte"};
         if (got.read_valid   !== want.read_valid)   bad = {bad, " read_valid"};
         if (got.send_byte    !== want.send_byte)    bad = {bad, " send_byte"};
         if (got.send_valid   !== want.send_valid)   bad = {bad, " send_valid"};
         if (got.rx_overflow  !== want.rx_overflow)  bad = {bad, " rx_overflow"};
         if (got.frame_flag   !== want.frame_flag)   bad = {bad, " frame_flag"};
         if (got.overrun_flag !== want.overrun_flag) bad = {bad, " overrun_flag"};
         if (got.parity_flag  !== want.parity_flag)  bad = {bad, " parity_flag"};
         if (got.tx_overflow  !== want.tx_overflow)  bad = {bad, " tx_overflow"};
         if (got.tx_pending   !== want.tx_pending)   bad = {bad, " tx_pending"};
         if (bad != "") begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
               $display("result mismatch in%s", bad);
               $display("   expected %s", describe(want));
               $display("   actual   %s", describe(got));
            end
         end
      endfunction

      function int pending();
         return expected_rsps.size();
      endfunction
   endclass

   // All block inputs start at known values at time zero.
   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   urtb_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   urtb_rsp_type rsp_data;

   // When set, the matching side runs back to back for the current segment.
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;
   int idle_cycles = 0;

   ring_buffer_predictor predictor = new();

   uart_rx_tx_ring_buffers i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic urtb_req_type make_req(req_kind_type kind, logic [7:0] data,
                                             logic fe, logic ov, logic pe);
      urtb_req_type req;
      req.req_type      = kind;
      req.data_byte     = data;
      req.frame_err_in  = fe;
      req.overrun_in    = ov;
      req.parity_err_in = pe;
      return req;
   endfunction

   // Random content; the kind leans toward the segment's favored kind unless
   // the segment is fully mixed. Status and data bits are always random, so
   // they also appear on kinds that must ignore them.
   function automatic urtb_req_type random_request(req_kind_type favored, bit mixed);
      urtb_req_type req;
      req.data_byte     = 8'($urandom_range(0, 255));
      req.frame_err_in  = 1'($urandom_range(0, 1));
      req.overrun_in    = 1'($urandom_range(0, 1));
      req.parity_err_in = 1'($urandom_range(0, 1));
      if (mixed || $urandom_range(0, 9) >= 7) begin
         req.req_type = 2'($urandom_range(0, 3));
      end else begin
         req.req_type = favored;
      end
      return req;
   endfunction

   // Offers one request item after a random gap and returns once it has been
   // accepted. Outputs are sampled right after the edge, so they still hold
   // the values that the edge itself saw. Exactly one assignment to req_valid
   // is made per time step: a zero gap keeps valid high into the next item.
   task automatic offer_request(input urtb_req_type item);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      predictor.note_request(item);
   endtask

   // Result side: stall for a random number of cycles before every item,
   // then hold ready until one result item has been taken and checked.
   initial begin : result_sink
      int gap;
      wait (!reset);
      forever begin
         gap = rsp_calm ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         predictor.check_response(rsp_data);
      end
   end

   // Any cycle without a handshake on either side counts toward the timeout.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      urtb_req_type directed [$];
      int           sent;
      int           seg_len;
      req_kind_type favored;
      bit           mixed;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reads and ready events on empty rings, with every ignored field set.
      directed.push_back(make_req(REQ_HOST_READ,  8'hFF, 1'b1, 1'b1, 1'b1));
      directed.push_back(make_req(REQ_TX_READY,   8'hA5, 1'b1, 1'b1, 1'b1));
      // Received bytes at the data extremes and with each status bit alone.
      directed.push_back(make_req(REQ_RX_BYTE,    8'h00, 1'b0, 1'b0, 1'b0));
      directed.push_back(make_req(REQ_RX_BYTE,    8'hFF, 1'b1, 1'b1, 1'b1));
      directed.push_back(make_req(REQ_RX_BYTE,    8'h5A, 1'b1, 1'b0, 1'b0));
      directed.push_back(make_req(REQ_RX_BYTE,    8'hA5, 1'b0, 1'b1, 1'b0));
      directed.push_back(make_req(REQ_RX_BYTE,    8'h3C, 1'b0, 1'b0, 1'b1));
      // Drain the receive ring in order, then read it once more while empty.
      repeat (6) directed.push_back(make_req(REQ_HOST_READ, 8'h00, 1'b0, 1'b0, 1'b0));
      // Host writes at the data extremes, then pop past empty.
      directed.push_back(make_req(REQ_HOST_WRITE, 8'h00, 1'b1, 1'b1, 1'b1));
      directed.push_back(make_req(REQ_HOST_WRITE, 8'hFF, 1'b0, 1'b0, 1'b0));
      repeat (3) directed.push_back(make_req(REQ_TX_READY, 8'hFF, 1'b0, 1'b0, 1'b0));
      // Interleaved traffic on both rings.
      directed.push_back(make_req(REQ_HOST_WRITE, 8'h81, 1'b0, 1'b0, 1'b0));
      directed.push_back(make_req(REQ_RX_BYTE,    8'h7E, 1'b1, 1'b1, 1'b1));
      directed.push_back(make_req(REQ_HOST_READ,  8'h00, 1'b1, 1'b0, 1'b1));
      directed.push_back(make_req(REQ_TX_READY,   8'h00, 1'b0, 1'b1, 1'b0));
      foreach (directed[i]) offer_request(directed[i]);

      // Random segments: each one favors a kind, so long fill segments run a
      // ring into overflow and drain segments run it dry. Some segments also
      // switch off idling on one or both sides.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         favored  = req_kind_type'(2'($urandom_range(0, 3)));
         mixed    = ($urandom_range(0, 4) == 0);
         seg_len  = $urandom_range(20, 150);
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         repeat (seg_len) begin
            offer_request(random_request(favored, mixed));
            sent++;
         end
      end
      req_valid <= 1'b0;
      rsp_calm  = 1'b0;

      // Let every predicted result arrive, then watch a little longer for
      // any stray result item.
      while (predictor.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (predictor.mismatch_cnt == 0 && predictor.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: uart_rx_tx_ring_buffers.f
sv/urtb_pkg.sv
sv/uart_rx_tx_ring_buffers.sv
test/tb_uart_rx_tx_ring_buffers.sv
